### hw/rtl/pse_pkg.sv
// shared types, constants and operation codes of the prime search engine
package pse_pkg;

  localparam int unsigned WIDTH = 32;
  localparam int unsigned CNT_W = $clog2(WIDTH);

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [1:0]       func_t;

  // operation codes; the code above FUNC_TEST acts as a test too
  localparam func_t FUNC_UP   = 2'd0;
  localparam func_t FUNC_DOWN = 2'd1;
  localparam func_t FUNC_TEST = 2'd2;

  localparam word_t FLIP_MASK      = WIDTH'(7);
  localparam word_t SMALLEST_PRIME = WIDTH'(2);
  localparam word_t WORD_MAX       = '1;

  // request to the shared divider
  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

  // status and result of the shared divider
  typedef struct packed {
    logic  busy;
    logic  done;
    word_t quotient;
    word_t remainder;
  } div_rsp_t;

endpackage

### hw/rtl/pse_if.sv
// valid/ready channel interfaces for the prime search engine

interface pse_in_if import pse_pkg::*; ();
  logic  valid;
  logic  ready;
  func_t func;
  word_t number;

  modport source (output valid, output func, output number, input ready);
  modport sink   (input valid, input func, input number, output ready);
endinterface

interface pse_out_if import pse_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t value;
  logic  prime_flag;
  logic  overflow;

  modport source (output valid, output value, output prime_flag, output overflow, input ready);
  modport sink   (input valid, input value, input prime_flag, input overflow, output ready);
endinterface

### hw/rtl/pse_div.sv
// restoring divider, one quotient bit per cycle, shared by all trial divisions
module pse_div import pse_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  word_t            quo_q, rem_q, dvs_q;

  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;
  logic             fits;
  word_t            rem_d;
  word_t            quo_d;

  // one restoring step
  always_comb begin
    shifted = {rem_q, quo_q[WIDTH-1]};
    diff    = shifted - {1'b0, dvs_q};
    fits    = shifted >= {1'b0, dvs_q};
    rem_d   = fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
    quo_d   = {quo_q[WIDTH-2:0], fits};
  end

  // step sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_W'(WIDTH - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

  // checks
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("divider restarted while busy");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q) else $error("divider did not start");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rem_q < dvs_q) else $error("remainder not below divisor");

endmodule

### hw/rtl/prime_search_engine.sv
// Prime search engine: tests a number for primality or searches for a prime upward
// or downward from an odd start, one beat in, one beat out; an even number is first
// XORed with 7 to give that start. Each candidate is checked by trial division with
// 2, 3 and then divisors of the form 6k+-1 up to its square root; all divisions run
// on one shared restoring divider. Special starting values (0, 1, 3, 5, 7, 11, 13,
// and 6 in either search direction) are answered without the divider. The block
// takes a new beat only when the previous item has been handed to the output
// register, which holds the result until it is taken.
module prime_search_engine import pse_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  pse_in_if.sink    req_i,
  pse_out_if.source rsp_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_DONE
  } state_e;

  state_e   state_q, state_d;
  func_t    func_q, func_d;
  word_t    cand_q, cand_d;
  word_t    trial_q, trial_d;
  logic     step4_q, step4_d;
  word_t    res_val_q, res_val_d;
  logic     res_flag_q, res_flag_d;
  logic     res_ovf_q, res_ovf_d;
  logic     out_valid_q, out_valid_d;
  word_t    out_val_q, out_val_d;
  logic     out_flag_q, out_flag_d;
  logic     out_ovf_q, out_ovf_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic     in_fire;
  logic     special;
  word_t    start_cand;

  assign req_i.ready = (state_q == ST_IDLE);
  assign in_fire     = req_i.valid && req_i.ready;

  // starting values that answer themselves, and the odd start of a search
  always_comb begin
    special    = (req_i.number == WIDTH'(3)) || (req_i.number == WIDTH'(5)) ||
                 (req_i.number == WIDTH'(7)) || (req_i.number == WIDTH'(11)) ||
                 (req_i.number == WIDTH'(13));
    start_cand = req_i.number[0] ? req_i.number : (req_i.number ^ FLIP_MASK);
  end

  pse_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    div_req.start    = (state_q == ST_START);
    div_req.dividend = cand_q;
    div_req.divisor  = trial_q;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    cand_d      = cand_q;
    trial_d     = trial_q;
    step4_d     = step4_q;
    res_val_d   = res_val_q;
    res_flag_d  = res_flag_q;
    res_ovf_d   = res_ovf_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_val_d   = out_val_q;
    out_flag_d  = out_flag_q;
    out_ovf_d   = out_ovf_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          func_d    = req_i.func;
          trial_d   = SMALLEST_PRIME;
          res_ovf_d = 1'b0;
          state_d   = ST_DONE;
          if (req_i.func[1]) begin
            // test only
            res_val_d  = req_i.number;
            res_flag_d = 1'b0;
            cand_d     = req_i.number;
            if (req_i.number >= SMALLEST_PRIME) begin
              state_d = ST_START;
            end
          end else if (req_i.number < SMALLEST_PRIME) begin
            res_val_d  = SMALLEST_PRIME;
            res_flag_d = 1'b1;
          end else if (special) begin
            res_val_d  = req_i.number;
            res_flag_d = 1'b1;
          end else if (start_cand < SMALLEST_PRIME) begin
            // a start that drops below two lands on two in either direction
            res_val_d  = SMALLEST_PRIME;
            res_flag_d = 1'b1;
          end else begin
            cand_d  = start_cand;
            state_d = ST_START;
          end
        end
      end
      ST_START: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_rsp.done) begin
          if (trial_q > div_rsp.quotient) begin
            // no divisor up to the square root
            res_val_d  = cand_q;
            res_flag_d = 1'b1;
            res_ovf_d  = 1'b0;
            state_d    = ST_DONE;
          end else if (div_rsp.remainder == '0) begin
            // composite candidate
            trial_d = SMALLEST_PRIME;
            if (func_q[1]) begin
              res_val_d  = cand_q;
              res_flag_d = 1'b0;
              res_ovf_d  = 1'b0;
              state_d    = ST_DONE;
            end else if (func_q == FUNC_UP) begin
              if (cand_q == WORD_MAX) begin
                res_val_d  = '0;
                res_flag_d = 1'b0;
                res_ovf_d  = 1'b1;
                state_d    = ST_DONE;
              end else begin
                cand_d  = cand_q + 1'b1;
                state_d = ST_START;
              end
            end else if (cand_q - 1'b1 < SMALLEST_PRIME) begin
              res_val_d  = SMALLEST_PRIME;
              res_flag_d = 1'b1;
              res_ovf_d  = 1'b0;
              state_d    = ST_DONE;
            end else begin
              cand_d  = cand_q - 1'b1;
              state_d = ST_START;
            end
          end else begin
            // next trial divisor: 2, 3, then 5, 7, 11, 13, ...
            state_d = ST_START;
            if (trial_q == SMALLEST_PRIME) begin
              trial_d = WIDTH'(3);
            end else if (trial_q == WIDTH'(3)) begin
              trial_d = WIDTH'(5);
              step4_d = 1'b0;
            end else begin
              trial_d = trial_q + (step4_q ? WIDTH'(4) : WIDTH'(2));
              step4_d = !step4_q;
            end
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_val_d   = res_val_q;
          out_flag_d  = res_flag_q;
          out_ovf_d   = res_ovf_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    cand_q     <= cand_d;
    trial_q    <= trial_d;
    step4_q    <= step4_d;
    res_val_q  <= res_val_d;
    res_flag_q <= res_flag_d;
    res_ovf_q  <= res_ovf_d;
    out_val_q  <= out_val_d;
    out_flag_q <= out_flag_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.value      = out_val_q;
  assign rsp_o.prime_flag = out_flag_q;
  assign rsp_o.overflow   = out_ovf_q;

  // checks
  a_ovf_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.overflow |-> (rsp_o.value == '0) && !rsp_o.prime_flag)
    else $error("overflow beat carries a value");
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_START) |-> !div_rsp.busy)
    else $error("division issued while divider busy");
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != ST_IDLE))
    else $error("accepted beat not in work");

endmodule

### tb/sv/tb_top.sv
// self-checking testbench for the prime search engine: directed table, then random beats
module tb_top;
  import pse_pkg::*;

  // the unused selector value, which the block treats as a primality test
  localparam func_t FUNC_SPARE = 2'd3;

  localparam int unsigned N_DIRECTED  = 25;
  localparam int unsigned N_RANDOM    = 115;
  localparam int unsigned MAX_WAIT    = 11;
  localparam int unsigned DRAIN_WAIT  = 100;
  localparam int unsigned IDLE_LIMIT  = 400000;
  localparam int unsigned MAX_REPORTS = 10;

  // one result beat
  typedef struct packed {
    word_t value;
    logic  prime_flag;
    logic  overflow;
  } prime_res_t;

  // one row of the directed table; the expectation is used only when typed is set
  typedef struct packed {
    func_t      func;
    word_t      number;
    logic       typed;
    prime_res_t result;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{FUNC_TEST,  32'd0,           1'b1, '{32'd0,           1'b0, 1'b0}},
    '{FUNC_TEST,  32'd1,           1'b1, '{32'd1,           1'b0, 1'b0}},
    '{FUNC_TEST,  32'd2,           1'b1, '{32'd2,           1'b1, 1'b0}},
    '{FUNC_TEST,  32'd3,           1'b1, '{32'd3,           1'b1, 1'b0}},
    '{FUNC_TEST,  32'd97,          1'b0, '{32'd0,           1'b0, 1'b0}},
    '{FUNC_TEST,  32'd91,          1'b0, '{32'd0,           1'b0, 1'b0}},
    '{FUNC_TEST,  32'hFFFF_FFFF,   1'b1, '{32'hFFFF_FFFF,   1'b0, 1'b0}},
    '{FUNC_TEST,  32'h8000_0000,   1'b1, '{32'h8000_0000,   1'b0, 1'b0}},
    '{FUNC_SPARE, 32'd9,           1'b1, '{32'd9,           1'b0, 1'b0}},
    '{FUNC_SPARE, 32'hFFFF_FFFE,   1'b1, '{32'hFFFF_FFFE,   1'b0, 1'b0}},
    '{FUNC_UP,    32'd0,           1'b1, '{32'd2,           1'b1, 1'b0}},
    '{FUNC_UP,    32'd1,           1'b1, '{32'd2,           1'b1, 1'b0}},
    '{FUNC_DOWN,  32'd0,           1'b1, '{32'd2,           1'b1, 1'b0}},
    '{FUNC_DOWN,  32'd1,           1'b1, '{32'd2,           1'b1, 1'b0}},
    '{FUNC_UP,    32'd3,           1'b1, '{32'd3,           1'b1, 1'b0}},
    '{FUNC_DOWN,  32'd13,          1'b1, '{32'd13,          1'b1, 1'b0}},
    '{FUNC_UP,    32'd7,           1'b0, '{32'd0,           1'b0, 1'b0}},
    '{FUNC_UP,    32'd11,          1'b0, '{32'd0,           1'b0, 1'b0}},
    '{FUNC_DOWN,  32'd5,           1'b0, '{32'd0,           1'b0, 1'b0}},
    '{FUNC_DOWN,  32'd6,           1'b1, '{32'd2,           1'b1, 1'b0}},
    '{FUNC_UP,    32'hFFFF_FFFF,   1'b1, '{32'd0,           1'b0, 1'b1}},
    '{FUNC_UP,    32'd8,           1'b0, '{32'd0,           1'b0, 1'b0}},
    '{FUNC_DOWN,  32'd8,           1'b0, '{32'd0,           1'b0, 1'b0}},
    '{FUNC_UP,    32'd2,           1'b0, '{32'd0,           1'b0, 1'b0}},
    '{FUNC_DOWN,  32'd10,          1'b0, '{32'd0,           1'b0, 1'b0}}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  pse_in_if  req_if ();
  pse_out_if rsp_if ();

  prime_search_engine dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  prime_res_t  pending_results [$];
  int unsigned sent_cnt;
  int unsigned taken_cnt;
  int unsigned mismatch_cnt;
  int unsigned idle_cycles = 0;

  // trial division by 2, 3 and 6k+-1 up to the square root
  function automatic logic prime_check(word_t n);
    longint unsigned v;
    longint unsigned d;
    v = n;
    if (v < 2) return 1'b0;
    if (v < 4) return 1'b1;
    if ((v % 2) == 0 || (v % 3) == 0) return 1'b0;
    for (d = 5; d <= v / d; d += 6) begin
      if ((v % d) == 0 || (v % (d + 2)) == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // expected result of one request beat
  function automatic prime_res_t predict_prime(func_t f, word_t n);
    prime_res_t r;
    word_t      c;
    logic       found;
    r = '0;
    if (f >= FUNC_TEST) begin
      r.value      = n;
      r.prime_flag = prime_check(n);
    end else if (n <= 1) begin
      r.value      = SMALLEST_PRIME;
      r.prime_flag = 1'b1;
    end else if (n == 3 || n == 5 || n == 7 || n == 11 || n == 13) begin
      r.value      = n;
      r.prime_flag = 1'b1;
    end else begin
      c = n;
      if (!c[0]) c = c ^ FLIP_MASK;
      if (f == FUNC_UP) begin
        // walk up; running off the top of the word gives overflow
        r.prime_flag = 1'b1;
        found = prime_check(c);
        while (!found) begin
          if (c == WORD_MAX) begin
            r.overflow   = 1'b1;
            r.prime_flag = 1'b0;
            c     = '0;
            found = 1'b1;
          end else begin
            c     = c + 1;
            found = prime_check(c);
          end
        end
        r.value = c;
      end else begin
        // walk down; falling below two answers two
        while (c >= 2 && !prime_check(c)) c = c - 1;
        if (c < 2) c = SMALLEST_PRIME;
        r.value      = c;
        r.prime_flag = 1'b1;
      end
    end
    return r;
  endfunction

  // one request beat, after a random gap except in quiet stretches
  task automatic send_number(input func_t f, input word_t n, input logic typed,
                             input prime_res_t given);
    int unsigned gap;
    prime_res_t  want;
    gap = (((sent_cnt / 16) % 3) == 0) ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid  <= 1'b1;
    req_if.func   <= f;
    req_if.number <= n;
    want = typed ? given : predict_prime(f, n);
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    pending_results.push_back(want);
    sent_cnt++;
  endtask

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // reset, directed table, random beats, drain and verdict
  initial begin
    int unsigned idx;
    int unsigned sel;
    func_t       f;
    word_t       n;
    sent_cnt      = 0;
    req_if.valid  <= 1'b0;
    req_if.func   <= FUNC_UP;
    req_if.number <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (idx = 0; idx < N_DIRECTED; idx++) begin
      send_number(DIRECTED_ROWS[idx].func, DIRECTED_ROWS[idx].number,
                  DIRECTED_ROWS[idx].typed, DIRECTED_ROWS[idx].result);
    end

    // search starts stay small so each prime costs little trial division;
    // full-width numbers go to the test modes with a small factor forced in
    for (idx = 0; idx < N_RANDOM; idx++) begin
      f   = func_t'($urandom_range(0, 3));
      sel = $urandom_range(0, 99);
      if (f >= FUNC_TEST && sel < 35) begin
        n = $urandom;
        case ($urandom_range(0, 2))
          0:       n[0] = 1'b0;
          1:       n = n - (n % 3);
          default: n = n - (n % 7);
        endcase
      end else if (sel < 15) begin
        n = $urandom_range(0, 15);
      end else if (sel < 88) begin
        n = $urandom_range(0, 4095);
      end else begin
        n = $urandom_range(0, 1 << 18);
      end
      send_number(f, n, 1'b0, '0);
    end
    req_if.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // result side: random stalls, then compare each beat with the oldest expectation
  initial begin
    int unsigned stall;
    prime_res_t  got;
    prime_res_t  want;
    taken_cnt    = 0;
    mismatch_cnt = 0;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = (((taken_cnt / 12) % 3) == 1) ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_if.valid) @(posedge clk_i);
      got = '{rsp_if.value, rsp_if.prime_flag, rsp_if.overflow};
      taken_cnt++;
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("unexpected result beat: value=%h prime_flag=%b overflow=%b",
                   got.value, got.prime_flag, got.overflow);
      end else begin
        want = pending_results.pop_front();
        if (got.value !== want.value || got.prime_flag !== want.prime_flag ||
            got.overflow !== want.overflow) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("result %0d: value exp %h got %h, flag exp %b got %b, ovf exp %b got %b",
                     taken_cnt, want.value, got.value, want.prime_flag, got.prime_flag,
                     want.overflow, got.overflow);
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
